// ===== design/cursor_sequence_buffer_core_assert.svh =====
// assertion macros for the cursor sequence buffer checker
`ifndef CURSOR_SEQUENCE_BUFFER_CORE_ASSERT_SVH
`define CURSOR_SEQUENCE_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define CSB_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cursor sequence buffer check failed");

// next-cycle implication, checked while out of reset
`define CSB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cursor sequence buffer check failed");

`endif

// ===== design/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants of the cursor sequence buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csb_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int MODE_W      = 3;
    localparam int IN_VALUE_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_COUNT_W = 5;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIRST   = 3'd0,
        MODE_ADVANCE = 3'd1,
        MODE_INSERT  = 3'd2,
        MODE_ATTACH  = 3'd3,
        MODE_REMOVE  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_NO_CURRENT = 2'd2
    } status_t;

    // what every cell of the row does with its entry
    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_OPEN,
        SHIFT_CLOSE
    } shift_op_t;

endpackage

// ===== design/cursor_sequence_buffer_core.sv =====
// A request is taken when in_valid is high and in_stall low; its result shows
// on the output once the row of cells has shifted as the request is taken and
// the entry under the cursor has then been read into the output register.
// in_stall stays high after each request until its result has moved into the
// output register, and longer while that register still holds a result that
// is stalled, so no new request is taken before the last result has moved on.
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core
// Ordered word buffer with a cursor, built as a row of shifting cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_sequence_buffer_core #(
    parameter int CAPACITY    = csb_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = csb_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [csb_pkg::MODE_W-1:0]         mode,
    input  logic [csb_pkg::IN_VALUE_W-1:0]     entry_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               has_current,
    output logic [csb_pkg::OUT_VALUE_W-1:0]    current_value,
    output logic [csb_pkg::OUT_COUNT_W-1:0]    entry_count,
    output logic [csb_pkg::STATUS_W-1:0]       status
);
    import csb_pkg::*;

    localparam int POS_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                   accept;
    logic                   result_take;
    shift_op_t              shift_op;
    logic [POS_W-1:0]       shift_pos;
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       cursor;
    status_t                ctrl_status;
    logic                   pending;
    logic [VALUE_WIDTH-1:0] wr_value;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_sel   [CAPACITY];
    logic [VALUE_WIDTH-1:0] read_value;

    logic                   out_valid_reg;
    logic                   has_current_reg;
    logic [OUT_VALUE_W-1:0] current_value_reg;
    logic [OUT_COUNT_W-1:0] entry_count_reg;
    status_t                status_reg;

    assign accept      = in_valid && !pending;
    assign result_take = pending && (!out_valid_reg || !out_stall);
    assign wr_value    = VALUE_WIDTH'(entry_value);

    csb_ctrl #(
        .CAPACITY (CAPACITY),
        .POS_W    (POS_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .result_take (result_take),
        .shift_op    (shift_op),
        .shift_pos   (shift_pos),
        .count       (count),
        .cursor      (cursor),
        .status      (ctrl_status),
        .pending     (pending)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        csb_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .POS_W       (POS_W),
            .CNT_W       (CNT_W),
            .INDEX       (i)
        ) u_cell (
            .clk         (clk),
            .shift_op    (shift_op),
            .shift_pos   (shift_pos),
            .new_value   (wr_value),
            .left_value  (left_value),
            .right_value (right_value),
            .cursor      (cursor),
            .value       (cell_value[i]),
            .sel_value   (cell_sel[i])
        );
    end

    // at most one cell is selected, so an or of all of them reads it out
    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_value = read_value | cell_sel[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take)
        begin
            has_current_reg   <= (cursor != '0);
            current_value_reg <= OUT_VALUE_W'(read_value);
            entry_count_reg   <= OUT_COUNT_W'(count);
            status_reg        <= ctrl_status;
        end
    end

    assign in_stall      = pending;
    assign out_valid     = out_valid_reg;
    assign has_current   = has_current_reg;
    assign current_value = current_value_reg;
    assign entry_count   = entry_count_reg;
    assign status        = status_reg;

endmodule

// ===== design/csb_cell.sv =====
// ----------------------------------------------------------------------------
// csb_cell
// One storage cell of the row: holds one entry, opens or closes a gap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csb_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int POS_W       = 4,
    parameter int CNT_W       = 5,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  csb_pkg::shift_op_t     shift_op,
    input  logic [POS_W-1:0]       shift_pos,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  logic [CNT_W-1:0]       cursor,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] sel_value
);
    import csb_pkg::*;

    localparam logic [POS_W-1:0] MY_POS    = POS_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CURSOR = CNT_W'(INDEX + 1);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (shift_op)
            SHIFT_OPEN:
            begin
                if (shift_pos == MY_POS)
                begin
                    value_next = new_value;
                end
                else if (MY_POS > shift_pos)
                begin
                    value_next = left_value;
                end
            end
            SHIFT_CLOSE:
            begin
                if (MY_POS >= shift_pos)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    // only the cell under the cursor drives the read-out tree
    assign sel_value = (cursor == MY_CURSOR) ? value_reg : '0;

endmodule

// ===== design/csb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csb_ctrl
// Count and cursor keeping; decodes each request into a row shift command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csb_ctrl #(
    parameter int CAPACITY = 16,
    parameter int POS_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [csb_pkg::MODE_W-1:0]    mode,
    input  logic                          result_take,
    output csb_pkg::shift_op_t            shift_op,
    output logic [POS_W-1:0]              shift_pos,
    output logic [CNT_W-1:0]              count,
    output logic [CNT_W-1:0]              cursor,
    output csb_pkg::status_t              status,
    output logic                          pending
);
    import csb_pkg::*;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    status_t          status_reg, status_next;
    logic             pending_reg;
    shift_op_t        op_c;
    logic [POS_W-1:0] pos_c;
    logic             full;

    assign full = (count_reg == FULL_COUNT);

    always_comb
    begin
        op_c        = SHIFT_HOLD;
        pos_c       = '0;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        status_next = ST_DONE;
        unique case (mode)
            MODE_FIRST:
            begin
                cursor_next = (count_reg != '0) ? ONE : '0;
            end
            MODE_ADVANCE:
            begin
                if (cursor_reg == '0)
                begin
                    status_next = ST_NO_CURRENT;
                end
                else
                begin
                    cursor_next = (cursor_reg == count_reg) ? '0 : cursor_reg + ONE;
                end
            end
            MODE_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op_c       = SHIFT_OPEN;
                    count_next = count_reg + ONE;
                    if (cursor_reg <= ONE)
                    begin
                        pos_c       = '0;
                        cursor_next = ONE;
                    end
                    else
                    begin
                        pos_c = POS_W'(cursor_reg - ONE);
                    end
                end
            end
            MODE_ATTACH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op_c       = SHIFT_OPEN;
                    count_next = count_reg + ONE;
                    // no current entry: append at the tail
                    if (cursor_reg == '0)
                    begin
                        pos_c       = POS_W'(count_reg);
                        cursor_next = count_reg + ONE;
                    end
                    else
                    begin
                        pos_c       = POS_W'(cursor_reg);
                        cursor_next = cursor_reg + ONE;
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (cursor_reg == '0)
                begin
                    status_next = ST_NO_CURRENT;
                end
                else
                begin
                    op_c        = SHIFT_CLOSE;
                    pos_c       = POS_W'(cursor_reg - ONE);
                    count_next  = count_reg - ONE;
                    // removing the tail leaves no current entry
                    cursor_next = (cursor_reg == count_reg) ? '0 : cursor_reg;
                end
            end
            default:
            begin
                op_c = SHIFT_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            status_reg  <= ST_DONE;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg   <= count_next;
                cursor_reg  <= cursor_next;
                status_reg  <= status_next;
                pending_reg <= 1'b1;
            end
            else if (result_take)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    assign shift_op  = accept ? op_c : SHIFT_HOLD;
    assign shift_pos = pos_c;
    assign count     = count_reg;
    assign cursor    = cursor_reg;
    assign status    = status_reg;
    assign pending   = pending_reg;

endmodule

// ===== design/csb_checker.sv =====
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks of the cursor sequence buffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cursor_sequence_buffer_core_assert.svh"

module csb_checker #(
    parameter int CAPACITY = csb_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [csb_pkg::MODE_W-1:0]         mode,
    input  logic [csb_pkg::IN_VALUE_W-1:0]     entry_value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               has_current,
    input  logic [csb_pkg::OUT_VALUE_W-1:0]    current_value,
    input  logic [csb_pkg::OUT_COUNT_W-1:0]    entry_count,
    input  logic [csb_pkg::STATUS_W-1:0]       status
);
    import csb_pkg::*;

    localparam logic [OUT_COUNT_W-1:0] FULL_OUT = OUT_COUNT_W'(CAPACITY);

    logic req_taken;
    logic has_payload;

    assign req_taken   = in_valid && !in_stall;
    assign has_payload = (mode != '0) || (entry_value != '0);

    // a stalled result stays offered
    `CSB_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid)
    // one request in flight: the input is stalled right after a request
    `CSB_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_taken && has_payload || req_taken,
        in_stall)
    // no current entry reads as zero
    `CSB_ASSERT_NOW(a_zero_without_current, clk, rst_n, out_valid && !has_current,
        current_value == '0)
    // a refusal for lack of a current entry leaves none
    `CSB_ASSERT_NOW(a_refused_no_current, clk, rst_n,
        out_valid && (status == ST_NO_CURRENT), !has_current)
    // a refusal for lack of room only happens at capacity
    `CSB_ASSERT_NOW(a_refused_full, clk, rst_n, out_valid && (status == ST_FULL),
        entry_count == FULL_OUT)

endmodule

bind cursor_sequence_buffer_core csb_checker #(.CAPACITY(CAPACITY)) u_csb_checker (.*);
